// ===== hw/rtl/spmc_pkg.sv =====
// shared types, constants and fixed-point helpers for the pair match block
`timescale 1ns / 1ps
package spmc_pkg;
	localparam int ANGLE_BITS_DEF     = 16;
	localparam int DIST_FRAC_BITS_DEF = 4;
	localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
	localparam logic [15:0] Z_LIMIT = 16'd655;

	localparam logic signed [31:0] K2  = -32'sd1324675879;
	localparam logic signed [31:0] K4  = 32'sd272375560;
	localparam logic signed [31:0] K6  = -32'sd22401992;
	localparam logic signed [31:0] K8  = 32'sd987048;
	localparam logic signed [31:0] K10 = -32'sd27060;
	localparam logic signed [31:0] K12 = 32'sd506;

	typedef enum logic [1:0] {
		MODE_PHYS = 2'd0,
		MODE_SKY_DZ = 2'd1,
		MODE_SKY_ERR = 2'd2,
		MODE_SKY = 2'd3
	} mode_t;

	typedef enum logic [0:0] {
		REG_MODE = 1'd0,
		REG_MAXSEP = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] cluster_theta;
		logic [15:0] cluster_phi;
		logic [15:0] cluster_distance;
		logic [15:0] cluster_redshift;
		logic [15:0] cluster_redshift_error;
		logic [15:0] source_theta;
		logic [15:0] source_phi;
		logic [15:0] source_distance;
		logic [15:0] source_redshift;
		logic [15:0] source_redshift_error;
	} pair_in_t;

	typedef struct packed {
		logic        is_match;
		logic [15:0] physical_separation;
		logic [15:0] sky_separation;
		logic [15:0] redshift_difference;
	} pair_out_t;

	// product of two Q30 values, truncated toward zero
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [63:0] q;
		begin
			p = 64'(a) * 64'(b);
			q = p >>> 30;
			if (p < 0 && p[29:0] != 30'd0)
				q = q + 64'sd1;
			qmul = q[31:0];
		end
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		begin
			if (v > 34'(Q_ONE))
				clamp_unit = Q_ONE;
			else if (v < -34'(Q_ONE))
				clamp_unit = -Q_ONE;
			else
				clamp_unit = v[31:0];
		end
	endfunction
endpackage

// ===== hw/rtl/spmc_cos.sv =====
// pipelined cosine of a 32-bit phase, q30 result
`timescale 1ns / 1ps
module spmc_cos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] cos_val
);
	// fold to first quadrant, square, six horner steps, sign
	logic        neg_s1;
	logic [30:0] r_fold;
	logic [31:0] s_s1;
	logic [61:0] sq;
	logic signed [31:0] acc_s2, acc_s3, acc_s4, acc_s5, acc_s6, acc_s7;
	logic signed [31:0] s_s2, s_s3, s_s4, s_s5, s_s6;
	logic neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic signed [31:0] res;

	always_comb begin
		r_fold = {1'b0, phase[29:0]};
		if (phase[31:30] == 2'd1 || phase[31:30] == 2'd3)
			r_fold = 31'h4000_0000 - {1'b0, phase[29:0]};
		sq = 62'(r_fold) * 62'(r_fold);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= sq[61:30];
			neg_s1 <= (phase[31:30] == 2'd1 || phase[31:30] == 2'd2);
			acc_s2 <= spmc_pkg::K10 + spmc_pkg::qmul(spmc_pkg::K12, s_s1);
			s_s2 <= s_s1; neg_s2 <= neg_s1;
			acc_s3 <= spmc_pkg::K8 + spmc_pkg::qmul(acc_s2, s_s2);
			s_s3 <= s_s2; neg_s3 <= neg_s2;
			acc_s4 <= spmc_pkg::K6 + spmc_pkg::qmul(acc_s3, s_s3);
			s_s4 <= s_s3; neg_s4 <= neg_s3;
			acc_s5 <= spmc_pkg::K4 + spmc_pkg::qmul(acc_s4, s_s4);
			s_s5 <= s_s4; neg_s5 <= neg_s4;
			acc_s6 <= spmc_pkg::K2 + spmc_pkg::qmul(acc_s5, s_s5);
			s_s6 <= s_s5; neg_s6 <= neg_s5;
			acc_s7 <= spmc_pkg::clamp_unit(34'(spmc_pkg::Q_ONE)
				+ 34'(spmc_pkg::qmul(acc_s6, s_s6)));
			neg_s7 <= neg_s6;
		end
	end

	assign res = neg_s7 ? -acc_s7 : acc_s7;
	assign cos_val = res;
endmodule

// ===== hw/rtl/spmc_isqrt.sv =====
// pipelined integer square root, saturated to 16 bits
`timescale 1ns / 1ps
module spmc_isqrt #(
	parameter int VW = 48
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VW-1:0] val,
	output logic [15:0]   root
);
	// two result bits per stage: one per sub-step, 17 bits of root cover saturation
	localparam int RB = 17;
	localparam int NS = (RB + 1) / 2;
	logic [VW-1:0] rem_s [NS+1];
	logic [RB-1:0] res_s [NS+1];
	logic          big_s [NS+1];
	logic [VW-1:0] rem_c [NS];
	logic [RB-1:0] res_c [NS];

	always_comb begin
		rem_s[0] = val;
		res_s[0] = '0;
		big_s[0] = (val >> (2 * RB)) != '0;
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [VW+1:0] trial;
		always_comb begin
			rem_c[g] = rem_s[g];
			res_c[g] = res_s[g];
			trial = '0;
			for (int k = 0; k < 2; k++) begin
				if (2 * g + k < RB) begin
					// gain of setting this root bit: root_so_far * 2^(2b+2) + 2^(2b)
					trial = ((VW+2)'(res_c[g]) << (2 * (RB - 1 - 2 * g - k) + 2))
						| ((VW+2)'(1) << (2 * (RB - 1 - 2 * g - k)));
					if ((VW+2)'(rem_c[g]) >= trial) begin
						rem_c[g] = rem_c[g] - trial[VW-1:0];
						res_c[g] = (res_c[g] << 1) | RB'(1);
					end else begin
						res_c[g] = res_c[g] << 1;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_c[g];
				res_s[g+1] <= res_c[g];
				big_s[g+1] <= big_s[g];
			end
		end
	end

	assign root = (big_s[NS] || res_s[NS][RB-1]) ? 16'hFFFF : res_s[NS][15:0];
endmodule

// ===== hw/rtl/sky_pair_match_criterion.sv =====
// top level of the sky pair match criterion pipeline
`timescale 1ns / 1ps
// sky pair match criterion
// one candidate pair (cluster and radio source) enters as a beat on the in
// channel (in_valid / in_ready / in_data); one result beat leaves on the out
// channel with the match flag, physical and sky separations and redshift
// difference
// the whole datapath is a single enable-gated pipeline: cosine units, the
// arc combination, the squared separations and two square-root pipes
// from the accepting edge to out_valid a beat passes seven cosine stages,
// three arc stages, three separation stages, nine root stages and the
// output register; throughput one pair per cycle while the receiver does
// not stall, every stage holding one beat
// when the receiver stalls with the last stage full the whole pipeline holds,
// nothing lost or repeated; in_ready follows the last stage being free or
// taken
// reset clears the valid bits and sets criterion_mode to 0 and
// max_separation to 1; configuration goes through the apb port at byte
// address 0 (mode) and 4 (limit in whole mpc)
module sky_pair_match_criterion #(
	parameter int ANGLE_BITS     = spmc_pkg::ANGLE_BITS_DEF,
	parameter int DIST_FRAC_BITS = spmc_pkg::DIST_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spmc_pkg::pair_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spmc_pkg::pair_out_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int COS_LAT = 8;
	localparam int SQ_LAT  = 9;
	localparam int NPIPE   = COS_LAT + 6 + SQ_LAT;
	localparam int LW      = 12 + DIST_FRAC_BITS;

	logic [1:0]  mode_q;
	logic [11:0] maxsep_q;
	logic        en;
	logic [NPIPE-1:0] vld_s;

	// config port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			maxsep_q <= 12'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == spmc_pkg::REG_MODE)
				mode_q <= pwdata[1:0];
			else
				maxsep_q <= pwdata[11:0];
		end
	end
	assign prdata = (paddr[2] == spmc_pkg::REG_MODE) ? {30'd0, mode_q} : {20'd0, maxsep_q};

	// whole pipe advances unless the output beat is held
	assign en = !vld_s[NPIPE-1] || out_ready;
	assign in_ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NPIPE-2:0], in_valid};
	end
	assign out_valid = vld_s[NPIPE-1];

	// phases
	function automatic logic [31:0] to_phase(input logic [15:0] a);
		logic [ANGLE_BITS-1:0] m;
		begin
			m = ANGLE_BITS'(a);
			to_phase = 32'(m) << (32 - ANGLE_BITS);
		end
	endfunction

	logic [31:0] pt1, pt2, pd;
	assign pt1 = to_phase(in_data.cluster_theta);
	assign pt2 = to_phase(in_data.source_theta);
	assign pd  = to_phase(in_data.cluster_phi) - to_phase(in_data.source_phi);

	logic signed [31:0] ct1, ct2, st1, st2, cpd;
	spmc_cos u_ct1 (.clk, .en, .phase(pt1), .cos_val(ct1));
	spmc_cos u_ct2 (.clk, .en, .phase(pt2), .cos_val(ct2));
	spmc_cos u_st1 (.clk, .en, .phase(pt1 - 32'h4000_0000), .cos_val(st1));
	spmc_cos u_st2 (.clk, .en, .phase(pt2 - 32'h4000_0000), .cos_val(st2));
	spmc_cos u_cpd (.clk, .en, .phase(pd), .cos_val(cpd));

	// payload delay line alongside the cosine units
	spmc_pkg::pair_in_t dly_s [COS_LAT+2];
	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= in_data;
			for (int i = 1; i < COS_LAT + 2; i++)
				dly_s[i] <= dly_s[i-1];
		end
	end

	// arc combination
	logic signed [31:0] cc_s1, ss_s1, cpd_s1, ssc_s2, cc_s2;
	logic [31:0] omc_s3;
	logic signed [33:0] ca_sum;
	always_comb ca_sum = 34'(cc_s2) + 34'(ssc_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1  <= spmc_pkg::qmul(ct1, ct2);
			ss_s1  <= spmc_pkg::qmul(st1, st2);
			cpd_s1 <= cpd;
			cc_s2  <= cc_s1;
			ssc_s2 <= spmc_pkg::qmul(ss_s1, cpd_s1);
			omc_s3 <= 32'(spmc_pkg::Q_ONE - spmc_pkg::clamp_unit(ca_sum));
		end
	end

	// distances, taken from the delay line aligned with omc_s3
	spmc_pkg::pair_in_t p_a;
	assign p_a = dly_s[COS_LAT+1];
	logic [15:0] d1, d2, dd;
	logic [16:0] ds;
	assign d1 = p_a.cluster_distance;
	assign d2 = p_a.source_distance;
	assign dd = d1 > d2 ? d1 - d2 : d2 - d1;
	assign ds = 17'(d1) + 17'(d2);

	logic [31:0] ddsq_s4, prod_s4, omc_s4;
	logic [33:0] dssq_s4;
	logic [15:0] dz_s4, e1_s4, e2_s4;
	logic [15:0] z1, z2;
	assign z1 = p_a.cluster_redshift;
	assign z2 = p_a.source_redshift;
	always_ff @(posedge clk) begin
		if (en) begin
			ddsq_s4 <= 32'(dd) * 32'(dd);
			prod_s4 <= 32'(d1) * 32'(d2);
			dssq_s4 <= 34'(ds) * 34'(ds);
			omc_s4  <= omc_s3;
			dz_s4   <= z1 > z2 ? z1 - z2 : z2 - z1;
			e1_s4   <= p_a.cluster_redshift_error;
			e2_s4   <= p_a.source_redshift_error;
		end
	end

	// split products: hi and lo halves of omc
	logic [47:0] ph_s5, pl_s5;
	logic [49:0] sh_s5, sl_s5;
	logic [31:0] ddsq_s5;
	logic [15:0] dz_s5, e1_s5, e2_s5;
	logic [15:0] dz_s6, e1_s6, e2_s6;
	logic [15:0] dz_q [SQ_LAT+1];
	logic        mt_q [SQ_LAT+1];
	always_ff @(posedge clk) begin
		if (en) begin
			ph_s5 <= 48'(prod_s4) * 48'(omc_s4[31:16]);
			pl_s5 <= 48'(prod_s4) * 48'(omc_s4[15:0]);
			sh_s5 <= 50'(dssq_s4) * 50'(omc_s4[31:16]);
			sl_s5 <= 50'(dssq_s4) * 50'(omc_s4[15:0]);
			ddsq_s5 <= ddsq_s4;
			dz_s5 <= dz_s4; e1_s5 <= e1_s4; e2_s5 <= e2_s4;
		end
	end

	logic [47:0] phys_sq_s6;
	logic [47:0] sky_sq_s6;
	logic [47:0] phs;
	logic [49:0] sks;
	always_comb begin
		phs = (ph_s5 + (pl_s5 >> 16)) >> 13;
		sks = (sh_s5 + (sl_s5 >> 16)) >> 16;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			phys_sq_s6 <= 48'(ddsq_s5) + phs;
			sky_sq_s6  <= sks[47:0];
			dz_s6 <= dz_s5; e1_s6 <= e1_s5; e2_s6 <= e2_s5;
		end
	end

	// criterion decision
	logic [LW-1:0]   lim;
	logic [2*LW-1:0] lim_sq;
	logic            sky_ok, match;
	assign lim = LW'(maxsep_q) << DIST_FRAC_BITS;
	assign lim_sq = (2*LW)'(lim) * (2*LW)'(lim);
	always_comb begin
		sky_ok = sky_sq_s6 <= 48'(lim_sq);
		case (spmc_pkg::mode_t'(mode_q))
			spmc_pkg::MODE_PHYS:    match = phys_sq_s6 <= 48'(lim_sq);
			spmc_pkg::MODE_SKY_DZ:  match = sky_ok && dz_s6 <= spmc_pkg::Z_LIMIT;
			spmc_pkg::MODE_SKY_ERR: match = sky_ok && ((e1_s6 == 16'd0 && e2_s6 == 16'd0)
				|| e1_s6 >= dz_s6 || e2_s6 >= dz_s6);
			default:                match = sky_ok;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_q[0] <= dz_s6;
			mt_q[0] <= match;
			for (int i = 1; i < SQ_LAT + 1; i++) begin
				dz_q[i] <= dz_q[i-1];
				mt_q[i] <= mt_q[i-1];
			end
		end
	end

	logic [15:0] phys_rt, sky_rt;
	spmc_isqrt #(.VW(48)) u_sq_phys (.clk, .en, .val(phys_sq_s6), .root(phys_rt));
	spmc_isqrt #(.VW(48)) u_sq_sky  (.clk, .en, .val(sky_sq_s6), .root(sky_rt));

	// output at last stage; isqrt pipe is SQ_LAT deep, so align by one
	logic [15:0] phys_q, sky_q;
	always_ff @(posedge clk) begin
		if (en) begin
			phys_q <= phys_rt;
			sky_q  <= sky_rt;
		end
	end
	assign out_data.is_match = mt_q[SQ_LAT];
	assign out_data.physical_separation = phys_q;
	assign out_data.sky_separation = sky_q;
	assign out_data.redshift_difference = dz_q[SQ_LAT];
endmodule
